// ===== rtl/msu_pkg.sv =====
`default_nettype none
package msu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_MANUAL   = 3'd1,
        MODE_AUTO     = 3'd2,
        MODE_DEGRADED = 3'd3,
        MODE_PROTECT  = 3'd4,
        MODE_EMERG    = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_TELEOP = 3'd1,
        KIND_NAV    = 3'd2,
        KIND_ODOM   = 3'd3,
        KIND_HEALTH = 3'd4,
        KIND_ESTOP  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        HLTH_STARTUP  = 3'd0,
        HLTH_EMERG    = 3'd1,
        HLTH_PROTECT  = 3'd2,
        HLTH_DEGRADED = 3'd3,
        HLTH_NORMAL   = 3'd4
    } t_health;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_ACTIVE  = 2'd1,
        ST_NO_DATA = 2'd2,
        ST_EMERG   = 2'd3
    } t_status;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int TICK_BITS     = 16;
    localparam int LIM_BITS      = 15;
    localparam int GAIN_BITS     = 16;
    localparam int IO_VEL_BITS   = 16;
    localparam int KIND_BITS     = 3;
    localparam int HEALTH_BITS   = 3;
    localparam int THR_SQ_BITS   = 2 * LIM_BITS;
    localparam int DEADBAND      = 4;

    localparam logic [GAIN_BITS-1:0] GAIN_ROUND = '1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIM_NORM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LIM_DEG  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH   = 3'd5;

    localparam logic [TICK_BITS-1:0] RST_TIMEOUT  = 16'd50;
    localparam logic [TICK_BITS-1:0] RST_HOLD     = 16'd500;
    localparam logic [LIM_BITS-1:0]  RST_LIM_NORM = 15'd4096;
    localparam logic [LIM_BITS-1:0]  RST_LIM_DEG  = 15'd1229;
    localparam logic [GAIN_BITS-1:0] RST_GAIN     = 16'd3277;
    localparam logic [LIM_BITS-1:0]  RST_THRESH   = 15'd205;

    typedef struct packed {
        logic [TICK_BITS-1:0]   timeout;
        logic [TICK_BITS-1:0]   hold;
        logic [LIM_BITS-1:0]    lim_norm;
        logic [LIM_BITS-1:0]    lim_deg;
        logic [GAIN_BITS-1:0]   gain;
        logic [THR_SQ_BITS-1:0] thr_sq;
    } t_cfg;

    typedef struct packed {
        logic                          vel_valid;
        logic signed [IO_VEL_BITS-1:0] x;
        logic signed [IO_VEL_BITS-1:0] y;
        logic signed [IO_VEL_BITS-1:0] turn;
        logic                          contactor;
        t_status                       status;
        t_mode                         mode;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/msu_cfg.sv =====
`default_nettype none
module msu_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_we,
    input  wire logic [msu_pkg::CFG_IDX_BITS-1:0]   i_idx,
    input  wire logic [msu_pkg::CFG_DATA_BITS-1:0]  i_data,
    output msu_pkg::t_cfg                           o_cfg
);
    import msu_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // threshold is kept squared for the odometry compare
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                CFG_TIMEOUT:  n_cfg.timeout  = i_data[TICK_BITS-1:0];
                CFG_HOLD:     n_cfg.hold     = i_data[TICK_BITS-1:0];
                CFG_LIM_NORM: n_cfg.lim_norm = i_data[LIM_BITS-1:0];
                CFG_LIM_DEG:  n_cfg.lim_deg  = i_data[LIM_BITS-1:0];
                CFG_GAIN:     n_cfg.gain     = i_data[GAIN_BITS-1:0];
                CFG_THRESH:   n_cfg.thr_sq   = THR_SQ_BITS'(i_data[LIM_BITS-1:0])
                                             * THR_SQ_BITS'(i_data[LIM_BITS-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout  <= RST_TIMEOUT;
            r_cfg.hold     <= RST_HOLD;
            r_cfg.lim_norm <= RST_LIM_NORM;
            r_cfg.lim_deg  <= RST_LIM_DEG;
            r_cfg.gain     <= RST_GAIN;
            r_cfg.thr_sq   <= THR_SQ_BITS'(RST_THRESH) * THR_SQ_BITS'(RST_THRESH);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/msu_ema.sv =====
`default_nettype none
module msu_ema #(
    parameter int VEL_BITS = 16
) (
    input  wire logic signed [VEL_BITS-1:0]         i_smooth,
    input  wire logic signed [VEL_BITS-1:0]         i_target,
    input  wire logic [msu_pkg::GAIN_BITS-1:0]      i_gain,
    output logic signed [VEL_BITS-1:0]              o_next
);
    import msu_pkg::*;

    localparam int DW = VEL_BITS + 1;
    localparam int PW = DW + GAIN_BITS + 1;
    localparam int SW = DW + 2;
    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VEL_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] VMIN = SW'(-(64'sd1 <<< (VEL_BITS - 1)));
    localparam logic signed [SW-1:0] DBND = SW'(DEADBAND);

    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic [PW-1:0]        prod;
    logic [DW:0]          step;
    logic signed [SW-1:0] step_s;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sat;

    // step rounds away from zero; outputs in the deadband become zero
    always_comb begin
        diff   = DW'(i_target) - DW'(i_smooth);
        mag    = diff[DW-1] ? (~diff + 1'b1) : diff;
        prod   = PW'(mag) * PW'(i_gain) + PW'(GAIN_ROUND);
        step   = prod[PW-1:GAIN_BITS];
        step_s = signed'({1'b0, step});
        sum    = diff[DW-1] ? (SW'(i_smooth) - step_s) : (SW'(i_smooth) + step_s);
        if (sum > VMAX) begin
            sat = VMAX;
        end else if (sum < VMIN) begin
            sat = VMIN;
        end else begin
            sat = sum;
        end
        if (sat <= DBND && sat >= -DBND) begin
            o_next = '0;
        end else begin
            o_next = sat[VEL_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/msu_core.sv =====
`default_nettype none
module msu_core #(
    parameter int VEL_BITS = 16,
    parameter int AGE_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_fire,
    input  wire logic [msu_pkg::KIND_BITS-1:0]         i_kind,
    input  wire logic signed [msu_pkg::IO_VEL_BITS-1:0] i_vel_x,
    input  wire logic signed [msu_pkg::IO_VEL_BITS-1:0] i_vel_y,
    input  wire logic signed [msu_pkg::IO_VEL_BITS-1:0] i_turn,
    input  wire logic [msu_pkg::HEALTH_BITS-1:0]       i_health,
    input  wire msu_pkg::t_cfg                         i_cfg,
    output msu_pkg::t_result                           o_res
);
    import msu_pkg::*;

    localparam int EW = (VEL_BITS > IO_VEL_BITS) ? VEL_BITS : IO_VEL_BITS;
    localparam int XW = EW + 1;
    localparam int AW = (AGE_BITS > TICK_BITS) ? AGE_BITS : TICK_BITS;
    localparam int SQW = 2 * IO_VEL_BITS + 1;
    localparam logic signed [XW-1:0] VMAX = XW'((64'sd1 <<< (VEL_BITS - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] VMIN = XW'(-(64'sd1 <<< (VEL_BITS - 1)));

    function automatic logic signed [VEL_BITS-1:0] sat_in(
        input logic signed [IO_VEL_BITS-1:0] v
    );
        logic signed [XW-1:0] e;
        e = XW'(v);
        if (e > VMAX) begin
            e = VMAX;
        end else if (e < VMIN) begin
            e = VMIN;
        end
        return e[VEL_BITS-1:0];
    endfunction

    function automatic logic signed [IO_VEL_BITS-1:0] to_io(
        input logic signed [VEL_BITS-1:0] v
    );
        logic signed [XW-1:0] e;
        e = XW'(v);
        return e[IO_VEL_BITS-1:0];
    endfunction

    function automatic logic signed [IO_VEL_BITS-1:0] clip_out(
        input logic signed [VEL_BITS-1:0] v,
        input logic [LIM_BITS-1:0]        lim
    );
        logic signed [XW-1:0] e;
        logic signed [XW-1:0] l;
        logic signed [XW-1:0] r;
        e = XW'(v);
        l = signed'(XW'(lim));
        if (e > l) begin
            r = l;
        end else if (e < -l) begin
            r = -l;
        end else begin
            r = e;
        end
        return r[IO_VEL_BITS-1:0];
    endfunction

    function automatic logic [IO_VEL_BITS-1:0] mag_of(
        input logic signed [VEL_BITS-1:0] v
    );
        logic signed [XW-1:0] e;
        e = XW'(v);
        if (e[XW-1]) begin
            e = -e;
        end
        return e[IO_VEL_BITS-1:0];
    endfunction

    t_mode                      r_mode,    n_mode;
    logic                       r_estop,   n_estop;
    logic                       r_contact, n_contact;
    logic [AGE_BITS-1:0]        r_tage,    n_tage;
    logic [AGE_BITS-1:0]        r_nage,    n_nage;
    logic signed [VEL_BITS-1:0] r_tgt [3];
    logic signed [VEL_BITS-1:0] n_tgt [3];
    logic signed [VEL_BITS-1:0] r_smo [3];
    logic signed [VEL_BITS-1:0] n_smo [3];

    logic signed [VEL_BITS-1:0] cmd [3];
    logic signed [VEL_BITS-1:0] tgt_t [3];
    logic signed [VEL_BITS-1:0] ema_out [3];
    logic [AGE_BITS-1:0]        tage_inc;
    logic [AGE_BITS-1:0]        nage_inc;
    logic                       timed_out;
    logic                       hold_active;
    logic [IO_VEL_BITS-1:0]     ax;
    logic [IO_VEL_BITS-1:0]     ay;
    logic [SQW-1:0]             speed_sq;
    logic                       moving;
    logic [LIM_BITS-1:0]        lim;
    t_result                    res;

    always_comb begin
        cmd[0]      = sat_in(i_vel_x);
        cmd[1]      = sat_in(i_vel_y);
        cmd[2]      = sat_in(i_turn);
        tage_inc    = (&r_tage) ? r_tage : r_tage + 1'b1;
        nage_inc    = (&r_nage) ? r_nage : r_nage + 1'b1;
        timed_out   = (AW'(tage_inc) > AW'(i_cfg.timeout))
                   && (AW'(nage_inc) > AW'(i_cfg.timeout));
        hold_active = AW'(r_tage) < AW'(i_cfg.hold);
        ax          = mag_of(cmd[0]);
        ay          = mag_of(cmd[1]);
        speed_sq    = SQW'(SQW'(ax) * SQW'(ax)) + SQW'(SQW'(ay) * SQW'(ay));
        moving      = speed_sq > SQW'(i_cfg.thr_sq);
        for (int i = 0; i < 3; i++) begin
            tgt_t[i] = timed_out ? '0 : r_tgt[i];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_ema
        msu_ema #(
            .VEL_BITS(VEL_BITS)
        ) u_ema (
            .i_smooth(r_smo[g]),
            .i_target(tgt_t[g]),
            .i_gain  (i_cfg.gain),
            .o_next  (ema_out[g])
        );
    end

    always_comb begin
        n_mode    = r_mode;
        n_estop   = r_estop;
        n_contact = r_contact;
        n_tage    = r_tage;
        n_nage    = r_nage;
        n_tgt     = r_tgt;
        n_smo     = r_smo;
        lim       = i_cfg.lim_norm;
        res       = '0;
        case (t_kind'(i_kind))
            KIND_TICK: begin
                n_tage = tage_inc;
                n_nage = nage_inc;
                if (r_estop) begin
                    res.vel_valid = 1'b1;
                    n_contact     = 1'b0;
                    res.status    = ST_EMERG;
                end else begin
                    if (timed_out) begin
                        if (r_mode != MODE_PROTECT) begin
                            n_mode = MODE_IDLE;
                        end
                        for (int i = 0; i < 3; i++) begin
                            n_tgt[i] = '0;
                        end
                        res.status = ST_NO_DATA;
                    end else begin
                        res.status = ST_ACTIVE;
                    end
                    for (int i = 0; i < 3; i++) begin
                        n_smo[i] = (n_mode == MODE_AUTO) ? tgt_t[i] : ema_out[i];
                    end
                    if (n_mode != MODE_PROTECT && n_mode != MODE_EMERG) begin
                        lim           = (n_mode == MODE_DEGRADED) ? i_cfg.lim_deg
                                                                  : i_cfg.lim_norm;
                        res.vel_valid = 1'b1;
                        res.x         = clip_out(n_smo[0], lim);
                        res.y         = clip_out(n_smo[1], lim);
                        res.turn      = to_io(n_smo[2]);
                    end
                end
            end
            KIND_TELEOP: begin
                if (!r_estop) begin
                    n_tage = '0;
                    n_mode = MODE_MANUAL;
                    n_tgt  = cmd;
                end
            end
            KIND_NAV: begin
                if (!r_estop) begin
                    n_nage = '0;
                    if (!hold_active && r_mode != MODE_PROTECT) begin
                        n_mode = MODE_AUTO;
                        n_tgt  = cmd;
                    end
                end
            end
            KIND_ODOM: begin
                if (r_mode == MODE_PROTECT && moving) begin
                    n_estop   = 1'b1;
                    n_mode    = MODE_EMERG;
                    n_contact = 1'b0;
                end
            end
            KIND_HEALTH: begin
                case (t_health'(i_health))
                    HLTH_STARTUP: begin
                        n_mode        = MODE_PROTECT;
                        res.vel_valid = 1'b1;
                        n_contact     = 1'b0;
                    end
                    HLTH_EMERG: begin
                        n_estop       = 1'b1;
                        res.vel_valid = 1'b1;
                        n_contact     = 1'b0;
                    end
                    HLTH_PROTECT: begin
                        n_mode        = MODE_PROTECT;
                        res.vel_valid = 1'b1;
                        n_contact     = 1'b1;
                    end
                    HLTH_DEGRADED: begin
                        n_mode    = MODE_DEGRADED;
                        n_contact = 1'b1;
                    end
                    HLTH_NORMAL: begin
                        if (!r_estop) begin
                            if (r_mode == MODE_PROTECT || r_mode == MODE_DEGRADED) begin
                                n_mode = MODE_IDLE;
                            end
                            n_contact = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_ESTOP: begin
                n_estop       = 1'b1;
                n_mode        = MODE_EMERG;
                res.vel_valid = 1'b1;
                n_contact     = 1'b0;
            end
            default: ;
        endcase
        res.contactor = n_contact;
        res.mode      = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_estop   <= 1'b0;
            r_contact <= 1'b1;
            r_tage    <= '0;
            r_nage    <= '0;
            for (int i = 0; i < 3; i++) begin
                r_tgt[i] <= '0;
                r_smo[i] <= '0;
            end
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_estop   <= n_estop;
            r_contact <= n_contact;
            r_tage    <= n_tage;
            r_nage    <= n_nage;
            r_tgt     <= n_tgt;
            r_smo     <= n_smo;
        end
    end

    assign o_res = res;

`ifndef SYNTHESIS
    a_estop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_estop |=> r_estop)
        else $error("e-stop latch released without reset");

    a_estop_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind == KIND_TICK && r_estop)
        |-> (res.vel_valid && !res.contactor && res.status == ST_EMERG
             && res.x == '0 && res.y == '0 && res.turn == '0))
        else $error("tick under e-stop did not issue a stop");

    a_status_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind != KIND_TICK) |-> (res.status == ST_NONE))
        else $error("status set on a non-tick transaction");

    a_quiet_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !res.vel_valid) |-> (res.x == '0 && res.y == '0 && res.turn == '0))
        else $error("velocity nonzero without vel_valid");

    a_emerg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_mode == MODE_EMERG && r_estop) |=> (!r_contact || i_kind == KIND_HEALTH)
        || $past(i_kind == KIND_HEALTH))
        else $error("contactor closed in latched emergency");
`endif

endmodule
`default_nettype wire

// ===== rtl/motion_safety_supervisor_unit.sv =====
// Each accepted transaction is held in the input register; its result then goes to the output register.
// Throughput: 1 transaction per cycle; the input register and the output register
//   advance together whenever the output register is empty or being taken.
// Every transaction is resolved in one pass through the event logic and EMA multipliers.
// Reset (synchronous, active low): idle mode, e-stop clear, contactor closed, ages and
//   velocities zero, configuration at defaults; no clearing pass, ready next cycle.
`default_nettype none
module motion_safety_supervisor_unit #(
    parameter int VEL_BITS = 16,
    parameter int AGE_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [msu_pkg::KIND_BITS-1:0]          i_kind,
    input  wire logic signed [msu_pkg::IO_VEL_BITS-1:0] i_vel_x,
    input  wire logic signed [msu_pkg::IO_VEL_BITS-1:0] i_vel_y,
    input  wire logic signed [msu_pkg::IO_VEL_BITS-1:0] i_turn_rate,
    input  wire logic [msu_pkg::HEALTH_BITS-1:0]        i_health_code,
    input  wire logic                                   i_cfg_we,
    input  wire logic [msu_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire logic [msu_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic                                        o_vel_valid,
    output logic signed [msu_pkg::IO_VEL_BITS-1:0]      o_out_x,
    output logic signed [msu_pkg::IO_VEL_BITS-1:0]      o_out_y,
    output logic signed [msu_pkg::IO_VEL_BITS-1:0]      o_out_turn,
    output logic                                        o_contactor_closed,
    output logic [1:0]                                  o_status,
    output logic [2:0]                                  o_mode_out
);
    import msu_pkg::*;

    logic                          r_in_vld;
    logic [KIND_BITS-1:0]          r_kind;
    logic signed [IO_VEL_BITS-1:0] r_vel_x;
    logic signed [IO_VEL_BITS-1:0] r_vel_y;
    logic signed [IO_VEL_BITS-1:0] r_turn;
    logic [HEALTH_BITS-1:0]        r_health;
    logic                          r_out_vld;
    t_result                       r_out;

    logic    adv;
    logic    in_take;
    t_cfg    cfg;
    t_result res;

    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    msu_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    msu_core #(
        .VEL_BITS(VEL_BITS),
        .AGE_BITS(AGE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_kind  (r_kind),
        .i_vel_x (r_vel_x),
        .i_vel_y (r_vel_y),
        .i_turn  (r_turn),
        .i_health(r_health),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind   <= i_kind;
            r_vel_x  <= i_vel_x;
            r_vel_y  <= i_vel_y;
            r_turn   <= i_turn_rate;
            r_health <= i_health_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_vel_valid        = r_out.vel_valid;
    assign o_out_x            = r_out.x;
    assign o_out_y            = r_out.y;
    assign o_out_turn         = r_out.turn;
    assign o_contactor_closed = r_out.contactor;
    assign o_status           = r_out.status;
    assign o_mode_out         = r_out.mode;

endmodule
`default_nettype wire
